FILE: src/dnsap_pkg.sv
// Shared types and constants for the DNS response A-record parser.
`default_nettype none

package dnsap_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_RESOLVED = 2'd0,
        ST_SRV_ERR  = 2'd1,
        ST_NO_A     = 2'd2,
        ST_TIMEOUT  = 2'd3
    } t_status;

    localparam int unsigned TICK_W = 24;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd5000;
    localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};

    localparam logic [3:0]  HDR_LAST     = 4'd11;
    localparam logic [3:0]  HDR_RCODE    = 4'd3;
    localparam logic [3:0]  HDR_ANC_HI   = 4'd6;
    localparam logic [3:0]  HDR_ANC_LO   = 4'd7;
    localparam logic [3:0]  FIX_TYPE_HI  = 4'd0;
    localparam logic [3:0]  FIX_TYPE_LO  = 4'd1;
    localparam logic [3:0]  FIX_TTL_LO   = 4'd4;
    localparam logic [3:0]  FIX_TTL_HI   = 4'd7;
    localparam logic [3:0]  FIX_RDL_HI   = 4'd8;
    localparam logic [3:0]  FIX_LAST     = 4'd9;
    localparam logic [3:0]  ADDR_LAST    = 4'd3;
    localparam logic [15:0] QTAIL_LEN    = 16'd4;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [7:0]  PTR_MASK     = 8'hC0;

endpackage

`default_nettype wire

FILE: src/dnsap_if.sv
// Handshake interfaces for the parser's input and result channels.
`default_nettype none

interface dnsap_in_if
    import dnsap_pkg::*;
();
    logic       valid;
    logic       ready;
    t_op        operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface dnsap_out_if
    import dnsap_pkg::*;
();
    logic        valid;
    logic        ready;
    t_status     status;
    logic [3:0]  response_code;
    logic [31:0] address;
    logic [31:0] time_to_live;

    modport source (output valid, output status, output response_code, output address,
                    output time_to_live, input ready);
    modport sink   (input valid, input status, input response_code, input address,
                    input time_to_live, output ready);
endinterface

`default_nettype wire

FILE: src/dns_response_a_record_parser_top.sv
// DNS response A-record parser: top level.
// Input channel i_in carries one beat per item: operation (start, response
// byte or timer tick) and data_byte. A start arms the parser and clears the
// timer; bytes then walk the DNS header, question and answers, and ticks
// before the first byte count towards the timeout in i_cfg_wdata/i_cfg_we.
// Output channel o_out carries at most one result beat per query: resolved
// (address and TTL), server error (response code), no A record or timeout.
// An accepted beat sits in the input register and is processed from there;
// its result (if any) is written to the output register, which drives o_out.
// Throughput: one beat per cycle while no result waits on the receiver, set
// by the single input-register to output-register pass.
// If the receiver stalls with a result waiting, one more beat is held in the
// input register and i_in.ready then drops until the result is taken.
// Reset (synchronous, active low) disarms the parser, empties both
// registers and sets the timeout to 5000 ticks.
`default_nettype none

module dns_response_a_record_parser_top
    import dnsap_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [TICK_W-1:0]  i_cfg_wdata,
    dnsap_in_if.sink          i_in,
    dnsap_out_if.source       o_out
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_QNAME, PH_QLABEL, PH_QPTR, PH_QTAIL,
        PH_ANAME, PH_ALABEL, PH_APTR, PH_AFIXED, PH_AADDR, PH_ARDATA
    } t_phase;

    logic              r_in_valid;
    t_op               r_in_op;
    logic [7:0]        r_in_byte;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [3:0]        r_out_rc;
    logic [31:0]       r_out_addr;
    logic [31:0]       r_out_ttl;

    logic [TICK_W-1:0] r_timeout;
    logic              r_armed,      n_armed;
    t_phase            r_phase,      n_phase;
    logic [3:0]        r_byte_idx,   n_byte_idx;
    logic [15:0]       r_ans_left,   n_ans_left;
    logic [15:0]       r_skip,       n_skip;
    logic [15:0]       r_rec_type,   n_rec_type;
    logic [31:0]       r_ttl,        n_ttl;
    logic [31:0]       r_addr,       n_addr;
    logic [TICK_W-1:0] r_elapsed,    n_elapsed;
    logic              r_bytes_seen, n_bytes_seen;

    logic              w_adv;
    logic              w_proc;
    logic              w_res;
    t_status           w_res_status;
    logic [3:0]        w_res_rc;
    logic [31:0]       w_res_addr;
    logic [31:0]       w_res_ttl;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_proc     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.response_code = r_out_rc;
    assign o_out.address       = r_out_addr;
    assign o_out.time_to_live  = r_out_ttl;

    always_comb begin
        n_armed      = r_armed;
        n_phase      = r_phase;
        n_byte_idx   = r_byte_idx;
        n_ans_left   = r_ans_left;
        n_skip       = r_skip;
        n_rec_type   = r_rec_type;
        n_ttl        = r_ttl;
        n_addr       = r_addr;
        n_elapsed    = r_elapsed;
        n_bytes_seen = r_bytes_seen;
        w_res        = 1'b0;
        w_res_status = ST_RESOLVED;
        w_res_rc     = 4'd0;
        w_res_addr   = 32'd0;
        w_res_ttl    = 32'd0;

        if (w_proc) begin
            if (r_in_op == OP_START) begin
                n_armed      = 1'b1;
                n_phase      = PH_HDR;
                n_byte_idx   = 4'd0;
                n_ans_left   = 16'd0;
                n_skip       = 16'd0;
                n_rec_type   = 16'd0;
                n_ttl        = 32'd0;
                n_addr       = 32'd0;
                n_elapsed    = '0;
                n_bytes_seen = 1'b0;
            end else if (r_armed && r_in_op == OP_BYTE) begin
                n_bytes_seen = 1'b1;
                unique case (r_phase)
                    PH_HDR: begin
                        if (r_byte_idx == HDR_RCODE && r_in_byte[3:0] != 4'd0) begin
                            w_res        = 1'b1;
                            w_res_status = ST_SRV_ERR;
                            w_res_rc     = r_in_byte[3:0];
                        end else begin
                            if (r_byte_idx == HDR_ANC_HI) begin
                                n_ans_left = {r_in_byte, 8'd0};
                            end
                            if (r_byte_idx == HDR_ANC_LO) begin
                                n_ans_left = {r_ans_left[15:8], r_in_byte};
                            end
                            n_byte_idx = r_byte_idx + 4'd1;
                            if (r_byte_idx == HDR_LAST) begin
                                n_phase = PH_QNAME;
                            end
                        end
                    end
                    PH_QNAME, PH_ANAME: begin
                        if (r_in_byte == 8'd0) begin
                            if (r_phase == PH_QNAME) begin
                                n_phase = PH_QTAIL;
                                n_skip  = QTAIL_LEN;
                            end else begin
                                n_phase    = PH_AFIXED;
                                n_byte_idx = 4'd0;
                            end
                        end else if ((r_in_byte & PTR_MASK) == PTR_MASK) begin
                            n_phase = (r_phase == PH_QNAME) ? PH_QPTR : PH_APTR;
                        end else begin
                            n_skip  = {8'd0, r_in_byte};
                            n_phase = (r_phase == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                        end
                    end
                    PH_QLABEL, PH_ALABEL: begin
                        n_skip = r_skip - 16'd1;
                        if (n_skip == 16'd0) begin
                            n_phase = (r_phase == PH_QLABEL) ? PH_QNAME : PH_ANAME;
                        end
                    end
                    PH_QPTR: begin
                        n_phase = PH_QTAIL;
                        n_skip  = QTAIL_LEN;
                    end
                    PH_APTR: begin
                        n_phase    = PH_AFIXED;
                        n_byte_idx = 4'd0;
                    end
                    PH_QTAIL: begin
                        n_skip = r_skip - 16'd1;
                        if (n_skip == 16'd0) begin
                            if (r_ans_left == 16'd0) begin
                                w_res        = 1'b1;
                                w_res_status = ST_NO_A;
                            end else begin
                                n_phase = PH_ANAME;
                            end
                        end
                    end
                    PH_AFIXED: begin
                        if (r_byte_idx == FIX_TYPE_HI) begin
                            n_rec_type = {r_in_byte, 8'd0};
                        end else if (r_byte_idx == FIX_TYPE_LO) begin
                            n_rec_type = {r_rec_type[15:8], r_in_byte};
                        end else if (r_byte_idx >= FIX_TTL_LO && r_byte_idx <= FIX_TTL_HI) begin
                            n_ttl = {r_ttl[23:0], r_in_byte};
                        end else if (r_byte_idx == FIX_RDL_HI) begin
                            n_skip = {r_in_byte, 8'd0};
                        end else if (r_byte_idx == FIX_LAST) begin
                            n_skip = {r_skip[15:8], r_in_byte};
                        end
                        n_byte_idx = r_byte_idx + 4'd1;
                        if (r_byte_idx == FIX_LAST) begin
                            n_byte_idx = 4'd0;
                            if (n_rec_type == TYPE_A) begin
                                n_phase = PH_AADDR;
                            end else if (n_skip == 16'd0) begin
                                n_ans_left = r_ans_left - 16'd1;
                                if (n_ans_left == 16'd0) begin
                                    w_res        = 1'b1;
                                    w_res_status = ST_NO_A;
                                end else begin
                                    n_phase = PH_ANAME;
                                end
                            end else begin
                                n_phase = PH_ARDATA;
                            end
                        end
                    end
                    PH_AADDR: begin
                        n_addr     = {r_addr[23:0], r_in_byte};
                        n_byte_idx = r_byte_idx + 4'd1;
                        if (r_byte_idx == ADDR_LAST) begin
                            w_res        = 1'b1;
                            w_res_status = ST_RESOLVED;
                            w_res_addr   = n_addr;
                            w_res_ttl    = r_ttl;
                        end
                    end
                    PH_ARDATA: begin
                        n_skip = r_skip - 16'd1;
                        if (n_skip == 16'd0) begin
                            n_ans_left = r_ans_left - 16'd1;
                            if (n_ans_left == 16'd0) begin
                                w_res        = 1'b1;
                                w_res_status = ST_NO_A;
                            end else begin
                                n_phase = PH_ANAME;
                            end
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end else if (r_armed && r_in_op == OP_TICK && !r_bytes_seen) begin
                if (r_elapsed != TICK_MAX) begin
                    n_elapsed = r_elapsed + 24'd1;
                end
                if (n_elapsed > r_timeout) begin
                    w_res        = 1'b1;
                    w_res_status = ST_TIMEOUT;
                end
            end

            if (w_res) begin
                n_armed = 1'b0;
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_timeout    <= TIMEOUT_RESET;
            r_armed      <= 1'b0;
            r_phase      <= PH_IDLE;
            r_byte_idx   <= 4'd0;
            r_ans_left   <= 16'd0;
            r_skip       <= 16'd0;
            r_rec_type   <= 16'd0;
            r_ttl        <= 32'd0;
            r_addr       <= 32'd0;
            r_elapsed    <= '0;
            r_bytes_seen <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= w_res;
            end
            r_armed      <= n_armed;
            r_phase      <= n_phase;
            r_byte_idx   <= n_byte_idx;
            r_ans_left   <= n_ans_left;
            r_skip       <= n_skip;
            r_rec_type   <= n_rec_type;
            r_ttl        <= n_ttl;
            r_addr       <= n_addr;
            r_elapsed    <= n_elapsed;
            r_bytes_seen <= n_bytes_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.operation;
            r_in_byte <= i_in.data_byte;
        end
        if (w_res) begin
            r_out_status <= w_res_status;
            r_out_rc     <= w_res_rc;
            r_out_addr   <= w_res_addr;
            r_out_ttl    <= w_res_ttl;
        end
    end

    // result only while armed, and it always disarms
    a_res_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res |-> r_armed)
        else $error("result raised while parser not armed");

    a_res_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res |=> (!r_armed && r_phase == PH_IDLE))
        else $error("parser still armed after a result");

    a_armed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed == (r_phase != PH_IDLE))
        else $error("armed flag and phase disagree");

    a_timeout_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res && w_res_status == ST_TIMEOUT) |-> !r_bytes_seen)
        else $error("timeout after first response byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_op) && $stable(r_in_byte)))
        else $error("held input beat lost while output stalled");

endmodule

`default_nettype wire

FILE: sim/dns_response_a_record_parser_top_tb.sv
// Randomised handshake testbench for the DNS response A-record parser, self-checked by a predictor.
module dns_response_a_record_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dnsap_pkg::*;

    localparam logic [TICK_W-1:0] TICKS_AT_RESET = 24'd5000;
    localparam logic [TICK_W-1:0] TICKS_CEILING  = {TICK_W{1'b1}};
    localparam logic [3:0]  OFS_RCODE      = 4'd3;
    localparam logic [3:0]  OFS_ANCOUNT_HI = 4'd6;
    localparam logic [3:0]  OFS_ANCOUNT_LO = 4'd7;
    localparam logic [3:0]  OFS_HDR_LAST   = 4'd11;
    localparam logic [3:0]  OFS_TYPE_HI    = 4'd0;
    localparam logic [3:0]  OFS_TYPE_LO    = 4'd1;
    localparam logic [3:0]  OFS_TTL_FIRST  = 4'd4;
    localparam logic [3:0]  OFS_TTL_LAST   = 4'd7;
    localparam logic [3:0]  OFS_RDLEN_HI   = 4'd8;
    localparam logic [3:0]  OFS_RDLEN_LO   = 4'd9;
    localparam logic [3:0]  FIXED_LEN      = 4'd10;
    localparam logic [3:0]  ADDR_LEN       = 4'd4;
    localparam logic [15:0] QUESTION_TAIL  = 16'd4;
    localparam logic [15:0] RR_TYPE_A      = 16'd1;
    localparam logic [7:0]  NAME_PTR       = 8'hC0;
    localparam int unsigned PHASE_ITEMS    = 230;
    localparam int unsigned IDLE_LIMIT     = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [3:0] {
        P_IDLE, P_HDR, P_QNAME, P_QLABEL, P_QPTR, P_QTAIL,
        P_ANAME, P_ALABEL, P_APTR, P_AFIXED, P_AADDR, P_ARDATA
    } t_parse_phase;

    typedef struct packed {
        t_status     status;
        logic [3:0]  rcode;
        logic [31:0] addr;
        logic [31:0] ttl;
    } t_lookup;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_beat;

    class a_record_tracker;
        logic [TICK_W-1:0] timeout_limit;
        bit                armed;
        t_parse_phase      phase;
        logic [3:0]        idx;
        logic [15:0]       answers_left;
        logic [15:0]       skip_cnt;
        logic [15:0]       rr_type;
        logic [31:0]       ttl_acc;
        logic [31:0]       addr_acc;
        logic [TICK_W-1:0] ticks;
        bit                got_byte;
        t_lookup           awaited_lookups[$];
        int unsigned       errors;

        function new();
            timeout_limit = TICKS_AT_RESET;
            errors        = 0;
            rearm();
            armed = 1'b0;
            phase = P_IDLE;
        endfunction

        function void rearm();
            armed        = 1'b1;
            phase        = P_HDR;
            idx          = '0;
            answers_left = '0;
            skip_cnt     = '0;
            rr_type      = '0;
            ttl_acc      = '0;
            addr_acc     = '0;
            ticks        = '0;
            got_byte     = 1'b0;
        endfunction

        function void conclude(t_status st, logic [3:0] rc, logic [31:0] a, logic [31:0] t);
            t_lookup r;
            r.status = st;
            r.rcode  = rc;
            r.addr   = a;
            r.ttl    = t;
            awaited_lookups.push_back(r);
            armed = 1'b0;
            phase = P_IDLE;
        endfunction

        // true when the byte closes the name
        function bit name_byte(logic [7:0] b, t_parse_phase label_ph, t_parse_phase ptr_ph);
            if (b == 8'h00)
                return 1'b1;
            if ((b & NAME_PTR) == NAME_PTR) begin
                phase = ptr_ph;
            end else begin
                skip_cnt = {8'h00, b};
                phase    = label_ph;
            end
            return 1'b0;
        endfunction

        function void close_answer();
            answers_left = answers_left - 16'd1;
            if (answers_left == 16'd0)
                conclude(ST_NO_A, 4'd0, 32'd0, 32'd0);
            else
                phase = P_ANAME;
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                P_HDR: begin
                    if (idx == OFS_RCODE && b[3:0] != 4'd0) begin
                        conclude(ST_SRV_ERR, b[3:0], 32'd0, 32'd0);
                        return;
                    end
                    if (idx == OFS_ANCOUNT_HI)
                        answers_left = {b, 8'h00};
                    if (idx == OFS_ANCOUNT_LO)
                        answers_left[7:0] = b;
                    if (idx == OFS_HDR_LAST)
                        phase = P_QNAME;
                    idx = idx + 4'd1;
                end
                P_QNAME: begin
                    if (name_byte(b, P_QLABEL, P_QPTR)) begin
                        phase    = P_QTAIL;
                        skip_cnt = QUESTION_TAIL;
                    end
                end
                P_QLABEL: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        phase = P_QNAME;
                end
                P_QPTR: begin
                    phase    = P_QTAIL;
                    skip_cnt = QUESTION_TAIL;
                end
                P_QTAIL: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0) begin
                        if (answers_left == 16'd0)
                            conclude(ST_NO_A, 4'd0, 32'd0, 32'd0);
                        else
                            phase = P_ANAME;
                    end
                end
                P_ANAME: begin
                    if (name_byte(b, P_ALABEL, P_APTR)) begin
                        phase = P_AFIXED;
                        idx   = '0;
                    end
                end
                P_ALABEL: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        phase = P_ANAME;
                end
                P_APTR: begin
                    phase = P_AFIXED;
                    idx   = '0;
                end
                P_AFIXED: begin
                    if (idx == OFS_TYPE_HI)
                        rr_type = {b, 8'h00};
                    else if (idx == OFS_TYPE_LO)
                        rr_type[7:0] = b;
                    else if (idx >= OFS_TTL_FIRST && idx <= OFS_TTL_LAST)
                        ttl_acc = {ttl_acc[23:0], b};
                    else if (idx == OFS_RDLEN_HI)
                        skip_cnt = {b, 8'h00};
                    else if (idx == OFS_RDLEN_LO)
                        skip_cnt[7:0] = b;
                    idx = idx + 4'd1;
                    if (idx == FIXED_LEN) begin
                        idx = '0;
                        if (rr_type == RR_TYPE_A)
                            phase = P_AADDR;
                        else if (skip_cnt == 16'd0)
                            close_answer();
                        else
                            phase = P_ARDATA;
                    end
                end
                P_AADDR: begin
                    addr_acc = {addr_acc[23:0], b};
                    idx      = idx + 4'd1;
                    if (idx == ADDR_LEN)
                        conclude(ST_RESOLVED, 4'd0, addr_acc, ttl_acc);
                end
                P_ARDATA: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0)
                        close_answer();
                end
                default: ;
            endcase
        endfunction

        function void note_beat(t_op op, logic [7:0] b);
            if (op == OP_START) begin
                rearm();
                return;
            end
            if (!armed)
                return;
            if (op == OP_BYTE) begin
                got_byte = 1'b1;
                take_byte(b);
            end else if (op == OP_TICK && !got_byte) begin
                if (ticks != TICKS_CEILING)
                    ticks = ticks + 24'd1;
                if (ticks > timeout_limit)
                    conclude(ST_TIMEOUT, 4'd0, 32'd0, 32'd0);
            end
        endfunction

        function void check_result(t_lookup got);
            t_lookup want;
            if (awaited_lookups.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d rcode %0d addr %h ttl %h",
                             $realtime, got.status, got.rcode, got.addr, got.ttl);
                return;
            end
            want = awaited_lookups.pop_front();
            if (got.status !== want.status || got.rcode !== want.rcode ||
                got.addr !== want.addr || got.ttl !== want.ttl) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch (expected/actual) status %0d/%0d rcode %0d/%0d ",
                              "addr %h/%h ttl %h/%h"}, $realtime, want.status, got.status,
                             want.rcode, got.rcode, want.addr, got.addr, want.ttl, got.ttl);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [TICK_W-1:0] i_cfg_wdata;

    dnsap_in_if  in_if ();
    dnsap_out_if out_if ();

    dns_response_a_record_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    a_record_tracker sb;
    t_beat           beat_q[$];
    bit              in_calm;
    bit              out_calm;
    int unsigned     idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_beat(t_op op, logic [7:0] b);
        t_beat bt;
        bt.op   = op;
        bt.data = b;
        beat_q.push_back(bt);
    endfunction

    function automatic void add_name(int unsigned max_labels);
        int unsigned n;
        int unsigned len;
        n = $urandom_range(0, max_labels);
        repeat (n) begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 12);
            add_beat(OP_BYTE, 8'(len));
            repeat (len) add_beat(OP_BYTE, 8'($urandom));
        end
        if ($urandom_range(0, 1) == 1) begin
            add_beat(OP_BYTE, NAME_PTR | 8'($urandom));
            add_beat(OP_BYTE, 8'($urandom));
        end else begin
            add_beat(OP_BYTE, 8'h00);
        end
    endfunction

    // one response, mostly well formed; some are cut short or salted with stray beats
    function automatic void add_response();
        int unsigned first;
        int unsigned n_ans;
        int unsigned i;
        int unsigned rdlen;
        logic [15:0] ancount;
        logic [15:0] rtype;
        logic [7:0]  b;
        bit          is_a;
        t_beat       noise;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) add_beat(OP_BYTE, 8'($urandom));
        first = beat_q.size();
        add_beat(OP_START, 8'($urandom));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) add_beat(OP_TICK, 8'($urandom));
        n_ans   = $urandom_range(0, 4);
        ancount = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(n_ans);
        for (i = 0; i < 12; i++) begin
            b = 8'($urandom);
            if (i == OFS_RCODE && $urandom_range(0, 9) != 0)
                b[3:0] = 4'd0;
            if (i == OFS_ANCOUNT_HI)
                b = ancount[15:8];
            if (i == OFS_ANCOUNT_LO)
                b = ancount[7:0];
            add_beat(OP_BYTE, b);
        end
        add_name(3);
        repeat (QUESTION_TAIL) add_beat(OP_BYTE, 8'($urandom));
        for (i = 0; i < n_ans; i++) begin
            add_name(1);
            is_a = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       rtype = 16'h0100;
                1:       rtype = 16'h0101;
                2:       rtype = 16'h001C;
                default: rtype = 16'($urandom);
            endcase
            if (is_a)
                rtype = RR_TYPE_A;
            else if (rtype == RR_TYPE_A)
                rtype = 16'h0005;
            add_beat(OP_BYTE, rtype[15:8]);
            add_beat(OP_BYTE, rtype[7:0]);
            repeat (6) add_beat(OP_BYTE, 8'($urandom));
            if (is_a)
                rdlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 4;
            else
                rdlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            add_beat(OP_BYTE, 8'(rdlen >> 8));
            add_beat(OP_BYTE, 8'(rdlen));
            repeat (is_a ? ADDR_LEN : rdlen) add_beat(OP_BYTE, 8'($urandom));
            if (is_a)
                break;
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, beat_q.size() - first - 1)) void'(beat_q.pop_back());
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 2))
                    0:       noise.op = OP_NONE;
                    1:       noise.op = OP_TICK;
                    default: noise.op = OP_BYTE;
                endcase
                noise.data = 8'($urandom);
                beat_q.insert($urandom_range(first + 1, beat_q.size()), noise);
            end
        end
    endfunction

    task automatic send_beat(t_beat bt);
        int unsigned gap;
        gap = pick_gap(in_calm);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= bt.op;
        in_if.data_byte <= bt.data;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_beat(bt.op, bt.data);
    endtask

    task automatic play_beats();
        while (beat_q.size() != 0)
            send_beat(beat_q.pop_front());
    endtask

    task automatic run_random(int unsigned n);
        int unsigned sent;
        sent = 0;
        while (sent < n) begin
            in_calm = ($urandom_range(0, 4) == 0);
            add_response();
            sent += beat_q.size();
            play_beats();
        end
    endtask

    // let all results land and the input register empty before touching config
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.awaited_lookups.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [TICK_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.timeout_limit = v;
    endtask

    initial begin
        logic [TICK_W-1:0] timeout_plan [6];
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_NONE;
        in_if.data_byte <= 8'h00;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_rst_n         <= 1'b0;
        sb = new();
        timeout_plan = '{24'd0, TICKS_CEILING, 24'($urandom_range(1, 6)), 24'($urandom),
                         TICKS_AT_RESET, 24'd2};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unarmed beats are dropped
        add_beat(OP_BYTE, 8'hFF);
        add_beat(OP_NONE, 8'h00);
        add_beat(OP_TICK, 8'hFF);
        // server error, response code at its top value
        add_beat(OP_START, 8'h00);
        repeat (4) add_beat(OP_BYTE, 8'hFF);
        // no answers, question name as a pointer
        add_beat(OP_START, 8'hFF);
        repeat (3) add_beat(OP_BYTE, 8'h00);
        add_beat(OP_BYTE, 8'hF0);
        repeat (2) add_beat(OP_BYTE, 8'hFF);
        repeat (2) add_beat(OP_BYTE, 8'h00);
        repeat (4) add_beat(OP_BYTE, 8'hFF);
        add_beat(OP_BYTE, 8'hFF);
        add_beat(OP_BYTE, 8'h00);
        repeat (4) add_beat(OP_BYTE, 8'hFF);
        play_beats();

        run_random(PHASE_ITEMS);
        foreach (timeout_plan[i]) begin
            settle();
            set_timeout(timeout_plan[i]);
            run_random(PHASE_ITEMS);
        end
        settle();

        if (sb.errors == 0 && sb.awaited_lookups.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned cyc;
        int unsigned hold;
        t_lookup     got;
        cyc  = 0;
        hold = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got.status = out_if.status;
                got.rcode  = out_if.response_code;
                got.addr   = out_if.address;
                got.ttl    = out_if.time_to_live;
                sb.check_result(got);
            end
            if (cyc % 256 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            cyc++;
            if (hold != 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
                hold = pick_gap(out_calm);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
